>>> rtl/edge_normalized_smoothing_filter_macros.svh
// assertion macros shared by the checker
`ifndef EDGE_NORMALIZED_SMOOTHING_FILTER_MACROS_SVH
`define EDGE_NORMALIZED_SMOOTHING_FILTER_MACROS_SVH
// implication checked every cycle outside reset
`define ENSF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ensf check failed");
// next-cycle implication checked outside reset
`define ENSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ensf check failed");
`endif

>>> rtl/ensf_pkg.sv
// shared types and constants for the smoothing filter
`default_nettype none
package ensf_pkg;
  localparam int unsigned NUM_REGS = 7;
  localparam int unsigned WEIGHT_W = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET [NUM_REGS] = '{
    8'd1, 8'd2, 8'd4, 8'd8, 8'd4, 8'd2, 8'd1};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV,
    ST_OUT
  } state_t;

  // one step handed down the row of cells
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;
endpackage
`default_nettype wire

>>> rtl/ensf_stream_if.sv
// valid/ready stream channel carrying a sample and a last flag
`default_nettype none
interface ensf_stream_if #(parameter int W = 24);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  logic         last;
  modport source (output valid, data, last, input ready);
  modport sink (input valid, data, last, output ready);
endinterface
`default_nettype wire

>>> rtl/ensf_cell.sv
// one cell of the sample row: holds one sample
`default_nettype none
module ensf_cell #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic                          clk,
  input  wire ensf_pkg::cell_ctl_t           ctl,
  input  wire logic [SAMPLE_WIDTH-1:0]       load_sample,
  input  wire logic [SAMPLE_WIDTH-1:0]       prev_sample,
  output      logic [SAMPLE_WIDTH-1:0]       sample_q
);
  logic [SAMPLE_WIDTH-1:0] sample_r;
  // shift in from neighbor, or load the input sample when clear is set
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      sample_r <= prev_sample;
    end else if (ctl.clear) begin
      sample_r <= load_sample;
    end
  end
  assign sample_q = sample_r;
endmodule
`default_nettype wire

>>> rtl/ensf_divider.sv
// restoring signed divider, one quotient bit per cycle, truncates toward zero
`default_nettype none
module ensf_divider #(
  parameter int NUM_W = 36,
  parameter int DEN_W = 11
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output      logic             done,
  output      logic signed [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic             neg_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;

  always_comb begin
    trial   = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
    diff    = {1'b0, trial} - {2'b00, den_r};
    q_nxt   = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (busy_r) begin
      if (!diff[DEN_W+1]) begin
        rem_nxt = diff[DEN_W:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) busy_nxt = 1'b0;
    end
  end

  // magnitude load and bit iteration
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num[NUM_W-1] ? NUM_W'(-num) : num;
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[NUM_W-1];
    end else begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done   <= 1'b0;
    end else begin
      done <= busy_r && !busy_nxt;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else begin
        busy_r <= busy_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  assign quo = neg_r ? NUM_W'(-$signed(q_r)) : $signed(q_r);
endmodule
`default_nettype wire

>>> rtl/edge_normalized_smoothing_filter.sv
// top level of the edge-normalized smoothing filter
// Samples move through a row of TAP_COUNT cells, one shift per accepted transfer.
// Each result is formed by a sequencer that walks the taps, one multiply-add per
// cycle, then a restoring divider giving one quotient bit per cycle. From its first
// tap to its transfer a result passes through the tap steps, the divider load, the
// SAMPLE_WIDTH + 12 quotient bits, the done strobe and the output state. A sample
// that flushes a sequence gives up to TAP_COUNT results, one after another. The
// next input is taken only once all results of the current one have been
// transferred.
`default_nettype none
module edge_normalized_smoothing_filter #(
  parameter int TAP_COUNT    = 7,
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ensf_stream_if.sink   in_s,
  ensf_stream_if.source out_s,
  input  wire logic                             cfg_we,
  input  wire logic [ensf_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [ensf_pkg::WEIGHT_W-1:0]    cfg_wdata
);
  localparam int HALF  = TAP_COUNT / 2;
  localparam int POS_W = $clog2(TAP_COUNT + 1);
  localparam int TAP_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int DEN_W = ensf_pkg::WEIGHT_W + 3;
  localparam int NUM_W = SAMPLE_WIDTH + DEN_W + 1;

  // tap weight registers
  logic [ensf_pkg::WEIGHT_W-1:0] weight_r [ensf_pkg::NUM_REGS];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ensf_pkg::NUM_REGS; i++) weight_r[i] <= ensf_pkg::WEIGHT_RESET[i];
    end else if (cfg_we && (32'(cfg_idx) < ensf_pkg::NUM_REGS)) begin
      weight_r[cfg_idx] <= cfg_wdata;
    end
  end

  // row of cells
  ensf_pkg::cell_ctl_t       cell_ctl;
  logic [SAMPLE_WIDTH-1:0]   win [TAP_COUNT];
  logic                      accept;
  assign accept = in_s.valid && in_s.ready;
  assign cell_ctl.shift = accept;
  assign cell_ctl.clear = 1'b0;
  for (genvar g = 0; g < TAP_COUNT; g++) begin : g_cell
    ensf_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .load_sample(in_s.data),
      .prev_sample((g == TAP_COUNT - 1) ? in_s.data : win[(g + 1) % TAP_COUNT]),
      .sample_q   (win[g])
    );
  end

  // control state
  ensf_pkg::state_t        state_r, state_nxt;
  logic [POS_W-1:0]        seen_r, seen_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [POS_W-1:0]        stop_r, stop_nxt;
  logic                    last_r, last_nxt;
  logic                    raw_r, raw_nxt;
  logic [TAP_W-1:0]        tap_r, tap_nxt;
  logic signed [NUM_W-1:0] acc_r;
  logic [DEN_W-1:0]        wsum_r;
  logic                    div_start_r, div_done;
  logic signed [NUM_W-1:0] quo;
  logic [SAMPLE_WIDTH-1:0] res_r;
  logic                    out_valid, out_last;
  logic [POS_W-1:0]        seen_inc;
  logic                    full_now;

  assign seen_inc = (seen_r < POS_W'(TAP_COUNT)) ? seen_r + POS_W'(1) : seen_r;
  assign full_now = (seen_inc == POS_W'(TAP_COUNT));

  // window index for current tap: pos + tap - HALF
  logic signed [POS_W+1:0] idx;
  logic                    in_range;
  logic [TAP_W-1:0]        idx_t;
  assign idx      = $signed({2'b00, pos_r}) + $signed({{(POS_W+2-TAP_W){1'b0}}, tap_r})
                    - (POS_W+2)'(HALF);
  assign in_range = (idx >= 0) && (idx < (POS_W+2)'(TAP_COUNT));
  assign idx_t    = TAP_W'(idx);

  logic signed [SAMPLE_WIDTH+ensf_pkg::WEIGHT_W:0] prod;
  assign prod = $signed({1'b0, weight_r[tap_r]}) * $signed(win[idx_t]);

  // next state
  always_comb begin
    state_nxt = state_r;
    seen_nxt = seen_r; pos_nxt = pos_r; stop_nxt = stop_r;
    last_nxt = last_r; raw_nxt = raw_r; tap_nxt = tap_r;
    unique case (state_r)
      ensf_pkg::ST_IDLE: begin
        if (accept) begin
          last_nxt = in_s.last;
          tap_nxt  = '0;
          if (full_now) begin
            pos_nxt  = (seen_r == POS_W'(TAP_COUNT)) ? POS_W'(HALF) : '0;
            stop_nxt = in_s.last ? POS_W'(TAP_COUNT - 1) : POS_W'(HALF);
            raw_nxt  = 1'b0;
            state_nxt = ensf_pkg::ST_MAC;
          end else if (in_s.last) begin
            pos_nxt  = POS_W'(TAP_COUNT) - seen_inc;
            stop_nxt = POS_W'(TAP_COUNT - 1);
            raw_nxt  = 1'b1;
            state_nxt = ensf_pkg::ST_OUT;
          end
          seen_nxt = in_s.last ? '0 : seen_inc;
        end
      end
      ensf_pkg::ST_MAC: begin
        tap_nxt = tap_r + TAP_W'(1);
        if (tap_r == TAP_W'(TAP_COUNT - 1)) state_nxt = ensf_pkg::ST_DIV;
      end
      ensf_pkg::ST_DIV: begin
        if (div_done) state_nxt = ensf_pkg::ST_OUT;
      end
      ensf_pkg::ST_OUT: begin
        if (out_s.ready) begin
          tap_nxt = '0;
          if (pos_r == stop_r) begin
            state_nxt = ensf_pkg::ST_IDLE;
          end else begin
            pos_nxt = pos_r + POS_W'(1);
            state_nxt = raw_r ? ensf_pkg::ST_OUT : ensf_pkg::ST_MAC;
          end
        end
      end
      default: state_nxt = ensf_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_s.ready = (state_r == ensf_pkg::ST_IDLE);
    out_valid  = (state_r == ensf_pkg::ST_OUT);
    out_last   = last_r && (pos_r == stop_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ensf_pkg::ST_IDLE;
      seen_r <= '0; pos_r <= '0; stop_r <= '0;
      last_r <= 1'b0; raw_r <= 1'b0; tap_r <= '0;
    end else begin
      state_r <= state_nxt;
      seen_r <= seen_nxt; pos_r <= pos_nxt; stop_r <= stop_nxt;
      last_r <= last_nxt; raw_r <= raw_nxt; tap_r <= tap_nxt;
    end
  end

  // divider starts once the last tap has been added
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_start_r <= 1'b0;
    end else begin
      div_start_r <= (state_r == ensf_pkg::ST_MAC) && (tap_r == TAP_W'(TAP_COUNT - 1));
    end
  end

  // accumulate weighted samples and weight sum, held through the divide
  always_ff @(posedge clk) begin
    if (state_r == ensf_pkg::ST_MAC) begin
      if (in_range) begin
        acc_r  <= ((tap_r == '0) ? NUM_W'(0) : acc_r) + NUM_W'(prod);
        wsum_r <= ((tap_r == '0) ? DEN_W'(0) : wsum_r) + DEN_W'(weight_r[tap_r]);
      end else if (tap_r == '0) begin
        acc_r  <= '0;
        wsum_r <= '0;
      end
    end
  end

  ensf_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r),
    .num(acc_r), .den(wsum_r), .done(div_done), .quo(quo)
  );

  // result register
  always_ff @(posedge clk) begin
    if (div_done) begin
      res_r <= (wsum_r == '0) ? '0 : quo[SAMPLE_WIDTH-1:0];
    end
  end

  logic [TAP_W-1:0] raw_idx;
  assign raw_idx = TAP_W'(pos_r);
  assign out_s.valid = out_valid;
  assign out_s.data  = raw_r ? win[raw_idx] : res_r;
  assign out_s.last  = out_last;
endmodule
`default_nettype wire

>>> rtl/ensf_checker.sv
// port-level checks for the smoothing filter, bound to the top level
`default_nettype none
`include "edge_normalized_smoothing_filter_macros.svh"
module ensf_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last
);
  // no new transfer while a result is pending
  `ENSF_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  // a stalled result stays offered
  `ENSF_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // after the final result the input opens again
  `ENSF_ASSERT_NEXT(a_reopen, clk, rst_n, out_valid && out_ready && out_last, in_ready)
endmodule
bind edge_normalized_smoothing_filter ensf_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_s.ready),
  .out_valid(out_s.valid), .out_ready(out_s.ready), .out_last(out_s.last)
);
`default_nettype wire

>>> sim/tb.sv
// self-checking testbench for the edge-normalized smoothing filter
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS = 7;
  localparam int SW = 24;
  localparam int HALF = TAPS / 2;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_ITEMS = 76;

  // register indexes of the kernel weights
  typedef enum logic [ensf_pkg::CFG_IDX_W-1:0] {
    REG_W0, REG_W1, REG_W2, REG_W3, REG_W4, REG_W5, REG_W6
  } weight_reg_t;

  typedef struct packed {
    logic signed [SW-1:0] value;
    logic                 eor;
  } smooth_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ensf_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [ensf_pkg::WEIGHT_W-1:0] cfg_wdata = '0;

  ensf_stream_if #(.W(SW)) in_if ();
  ensf_stream_if #(.W(SW)) out_if ();

  edge_normalized_smoothing_filter #(.TAP_COUNT(TAPS), .SAMPLE_WIDTH(SW)) u_top (
    .clk(clk), .rst_n(rst_n), .in_s(in_if.sink), .out_s(out_if.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [ensf_pkg::WEIGHT_W-1:0] kernel [TAPS];
  logic signed [SW-1:0] history [TAPS];
  int held_count;
  smooth_out_t expected_q [$];

  int errors;
  int idle_cycles;
  bit stall_enable;

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    in_if.last = 1'b0;
    out_if.ready = 1'b0;
  end

  function automatic logic signed [SW-1:0] weighted_mean(int centre);
    longint acc;
    longint wsum;
    int idx;
    acc = 0;
    wsum = 0;
    for (int j = 0; j < TAPS; j++) begin
      idx = centre + j - HALF;
      if (idx >= 0 && idx < TAPS) begin
        acc += longint'(kernel[j]) * longint'(history[idx]);
        wsum += longint'(kernel[j]);
      end
    end
    if (wsum == 0) return '0;
    return SW'(acc / wsum);
  endfunction

  // predict the results of one accepted sample
  function automatic void predict_sample(logic signed [SW-1:0] x, logic is_last);
    bit was_full;
    int first;
    int stop;
    smooth_out_t r;
    was_full = held_count >= TAPS;
    for (int i = 0; i < TAPS - 1; i++) history[i] = history[i+1];
    history[TAPS-1] = x;
    if (held_count < TAPS) held_count++;
    if (held_count >= TAPS) begin
      first = was_full ? HALF : 0;
      stop = is_last ? TAPS - 1 : HALF;
      for (int i = first; i <= stop; i++) begin
        r.value = weighted_mean(i);
        r.eor = is_last && (i == stop);
        expected_q.push_back(r);
      end
    end else if (is_last) begin
      for (int i = TAPS - held_count; i < TAPS; i++) begin
        r.value = history[i];
        r.eor = (i == TAPS - 1);
        expected_q.push_back(r);
      end
    end
    if (is_last) held_count = 0;
  endfunction

  // check each result transfer against the oldest expectation
  always @(posedge clk) begin
    smooth_out_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result value=%0d eor=%0b", $signed(out_if.data), out_if.last);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_if.data !== exp_r.value) begin
          $error("smoothed_value expected %0d actual %0d", exp_r.value, $signed(out_if.data));
          errors++;
        end
        if (out_if.last !== exp_r.eor) begin
          $error("end_of_run expected %0b actual %0b", exp_r.eor, out_if.last);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (!stall_enable) out_if.ready <= 1'b1;
    else out_if.ready <= (r < 60) || ((r % 7) == 3);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  int burst_left;

  // send one sample, with bursty gaps; valid stays high within a burst
  task automatic send_sample(logic signed [SW-1:0] x, logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = stall_enable ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data <= x;
    in_if.last <= is_last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_sample(x, is_last);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_weight(weight_reg_t idx, logic [ensf_pkg::WEIGHT_W-1:0] w);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= w;
    @(posedge clk);
    kernel[idx] = w;
  endtask

  task automatic load_kernel(logic [ensf_pkg::WEIGHT_W-1:0] w [TAPS]);
    wait_idle();
    for (int i = 0; i < TAPS; i++) write_weight(weight_reg_t'(i), w[i]);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(SW-1){1'b1}}};
      1: return {1'b1, {(SW-1){1'b0}}};
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic send_sequence(int len);
    for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
  endtask

  // extremes, short sequences and a long flush at reset weights
  task automatic test_directed();
    send_sample(24'sh7FFFFF, 1'b1);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'sh7FFFFF, 1'b1);
    for (int i = 0; i < 7; i++) send_sample(i[0] ? 24'sh800000 : 24'sh7FFFFF, i == 6);
    for (int i = 0; i < 9; i++) send_sample(SW'(-i), i == 8);
  endtask

  // zero total weight and extreme weights
  task automatic test_weights();
    logic [ensf_pkg::WEIGHT_W-1:0] w [TAPS];
    w = '{default: 8'd0};
    load_kernel(w);
    send_sequence(8);
    w = '{default: 8'd255};
    load_kernel(w);
    send_sequence(10);
    w = '{8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0};
    load_kernel(w);
    send_sequence(7);
  endtask

  // random kernels and sequences under stalls
  task automatic test_random();
    logic [ensf_pkg::WEIGHT_W-1:0] w [TAPS];
    int sent;
    int len;
    stall_enable = 1'b1;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < TAPS; i++) w[i] = ensf_pkg::WEIGHT_W'($urandom);
        load_kernel(w);
      end
      if ($urandom_range(0, 4) == 0) len = $urandom_range(1, 6);
      else len = $urandom_range(7, 14);
      send_sequence(len);
      sent += len;
    end
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    held_count = 0;
    burst_left = 0;
    stall_enable = 1'b0;
    for (int i = 0; i < TAPS; i++) kernel[i] = ensf_pkg::WEIGHT_RESET[i];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_weights();
    test_random();
    wait_idle();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
+incdir+rtl
rtl/ensf_pkg.sv
rtl/ensf_stream_if.sv
rtl/ensf_cell.sv
rtl/ensf_divider.sv
rtl/edge_normalized_smoothing_filter.sv
rtl/ensf_checker.sv
sim/tb.sv
